[hdl/sspd_pkg.sv]
// Shared constants and types for the silence slice point detector.
`default_nettype none
package sspd_pkg;

    localparam int MAX_WINDOW_DEF = 4096;

    localparam int SAMPLE_W = 16;
    localparam int THR_W    = 16;
    localparam int WIN_W    = 13;
    localparam int HOP_W    = 13;
    localparam int GAP_W    = 32;
    localparam int POS_W    = 32;
    localparam int SUM_W    = 29;
    localparam int LIMIT_W  = THR_W + WIN_W;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int RES_N    = 3;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(100);
    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(2048);
    localparam logic [HOP_W-1:0] HOP_RESET = HOP_W'(512);
    localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(80000);

    localparam logic [POS_W-1:0] POS_MAX = '1;

    typedef enum logic [1:0] {
        REG_QUIET_THRESHOLD = 2'd0,
        REG_WINDOW_LENGTH   = 2'd1,
        REG_HOP_SIZE        = 2'd2,
        REG_MIN_GAP         = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                first;
        logic                full;
        logic                check;
        logic                last;
        logic [POS_W-1:0]    cut_pos;
        logic [POS_W-1:0]    end_pos;
    } work_t;

endpackage
`default_nettype wire

[hdl/silence_slice_point_detector.sv]
// Top level of the silence slice point detector: config port, sample ring and window check.
`default_nettype none
// Samples enter one per cycle while s_tready is high. Each transaction is registered in p1_reg
// together with a read of the sample ring (the sample leaving the window), and from there the
// running window sum is updated and checked; the cut points it causes go to a three-slot result
// register that drains one result per cycle while m_tready is high. An item is accepted every
// cycle except while that result register still holds results that do not all leave in the
// current cycle and the next item may add results (stream start, a window check or stream end);
// such items wait until the result register is free to take their results. Results:
// position 0 on the first sample, a cut point on a voiced/quiet change after enough length,
// and the stream length (with m_tlast) on the last sample.
module silence_slice_point_detector #(
    parameter int MAX_WINDOW = sspd_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sspd_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [sspd_pkg::PDATA_W-1:0]   pwdata,
    output logic      [sspd_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [sspd_pkg::SAMPLE_W-1:0]  s_tdata,   // [15:0] sample
    input  wire logic                           s_tlast,   // last_sample
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [sspd_pkg::POS_W-1:0]     m_tdata,   // [31:0] cut_position
    output logic                                m_tlast    // last_cut
);
    import sspd_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WINDOW);

    logic [THR_W-1:0]   thr_reg;
    logic [WIN_W-1:0]   win_reg;
    logic [HOP_W-1:0]   hop_reg;
    logic [GAP_W-1:0]   gap_reg;
    logic [LIMIT_W-1:0] limit_reg;

    logic [POS_W-1:0]   n_reg, n_next;
    logic [HOP_W-1:0]   hop_cnt_reg, hop_cnt_next;

    work_t              p1_reg, p1_next;
    logic               p1_valid_reg, p1_valid_next;
    logic [SAMPLE_W-1:0] ring_rd_reg;
    logic [SAMPLE_W-1:0] ring_mem [MAX_WINDOW];

    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [POS_W-1:0]   len_reg, len_next;
    logic               voiced_reg, voiced_next;

    logic [RES_N-1:0]   mask_reg, mask_next;
    logic [POS_W-1:0]   pos_reg [RES_N];

    logic               cfg_wr;
    logic               accept;
    logic [WIN_W-1:0]   w_eff;
    logic [HOP_W-1:0]   hop_eff;
    logic               full;
    logic               check;
    logic [POS_W:0]     n_inc;
    logic [POS_W-1:0]   n_sat;
    logic [POS_W-1:0]   rd_diff;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;

    logic               may_result;
    logic               bundle_free;
    logic               bundle_load;
    logic               p1_adv;
    logic               pop;
    logic [SUM_W-1:0]   mag;
    logic               quiet;
    logic               do_cut;
    logic [POS_W:0]     len_sum;
    logic [POS_W-1:0]   len_base;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
            win_reg <= WIN_RESET;
            hop_reg <= HOP_RESET;
            gap_reg <= GAP_RESET;
        end else if (cfg_wr) begin
            case (reg_idx_t'(paddr[3:2]))
                REG_QUIET_THRESHOLD: thr_reg <= pwdata[THR_W-1:0];
                REG_WINDOW_LENGTH:   win_reg <= pwdata[WIN_W-1:0];
                REG_HOP_SIZE:        hop_reg <= pwdata[HOP_W-1:0];
                REG_MIN_GAP:         gap_reg <= pwdata[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx_t'(paddr[3:2]))
            REG_QUIET_THRESHOLD: prdata = PDATA_W'(thr_reg);
            REG_WINDOW_LENGTH:   prdata = PDATA_W'(win_reg);
            REG_HOP_SIZE:        prdata = PDATA_W'(hop_reg);
            REG_MIN_GAP:         prdata = PDATA_W'(gap_reg);
            default:             prdata = '0;
        endcase
    end

    // effective window and hop
    always_comb begin
        if (win_reg == '0) begin
            w_eff = WIN_W'(1);
        end else if (32'(win_reg) > MAX_WINDOW) begin
            w_eff = WIN_W'(MAX_WINDOW);
        end else begin
            w_eff = win_reg;
        end
        hop_eff = (hop_reg == '0) ? HOP_W'(1) : hop_reg;
    end

    always_ff @(posedge aclk) begin
        limit_reg <= LIMIT_W'(thr_reg) * LIMIT_W'(w_eff);
    end

    // input stage
    assign accept  = s_tvalid & s_tready;
    assign full    = n_reg >= POS_W'(w_eff);
    assign check   = full && (hop_cnt_reg == '0);
    assign n_inc   = {1'b0, n_reg} + 1'b1;
    assign n_sat   = n_inc[POS_W] ? POS_MAX : n_inc[POS_W-1:0];
    assign rd_diff = n_reg - POS_W'(w_eff);
    assign wr_addr = n_reg[ADDR_W-1:0];
    assign rd_addr = rd_diff[ADDR_W-1:0];

    always_comb begin
        n_next       = n_reg;
        hop_cnt_next = hop_cnt_reg;
        if (accept) begin
            n_next = n_sat;
            if (full) begin
                hop_cnt_next = check ? hop_eff - 1'b1 : hop_cnt_reg - 1'b1;
            end
            if (s_tlast) begin
                n_next       = '0;
                hop_cnt_next = '0;
            end
        end
    end

    always_comb begin
        p1_next.sample  = s_tdata;
        p1_next.first   = (n_reg == '0);
        p1_next.full    = full;
        p1_next.check   = check;
        p1_next.last    = s_tlast;
        p1_next.cut_pos = n_reg - POS_W'(w_eff - (w_eff >> 1));
        p1_next.end_pos = n_sat;
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ring_mem[wr_addr] <= s_tdata;
            ring_rd_reg       <= ring_mem[rd_addr];
            p1_reg            <= p1_next;
        end
    end

    // window stage
    assign may_result  = p1_reg.first | p1_reg.check | p1_reg.last;
    assign pop         = m_tvalid & m_tready;
    assign bundle_free = (mask_reg == '0) || ($onehot(mask_reg) && m_tready);
    assign p1_adv      = !may_result || bundle_free;
    assign bundle_load = p1_valid_reg && may_result && bundle_free;
    assign s_tready    = !p1_valid_reg || p1_adv;

    assign mag    = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign quiet  = mag < limit_reg;
    assign do_cut = p1_reg.check && ((!quiet) != voiced_reg) && (len_reg > gap_reg);

    always_comb begin
        len_base = do_cut ? '0 : len_reg;
        len_sum  = {1'b0, len_base} + (POS_W + 1)'(hop_eff);
    end

    always_comb begin
        p1_valid_next = p1_valid_reg;
        sum_next      = sum_reg;
        len_next      = len_reg;
        voiced_next   = voiced_reg;
        if (p1_valid_reg && p1_adv) begin
            p1_valid_next = 1'b0;
            sum_next = sum_reg + {{(SUM_W - SAMPLE_W){p1_reg.sample[SAMPLE_W-1]}}, p1_reg.sample}
                     - (p1_reg.full
                        ? {{(SUM_W - SAMPLE_W){ring_rd_reg[SAMPLE_W-1]}}, ring_rd_reg}
                        : SUM_W'(0));
            if (p1_reg.check) begin
                voiced_next = !quiet;
                len_next    = len_sum[POS_W] ? POS_MAX : len_sum[POS_W-1:0];
            end
            if (p1_reg.last) begin
                sum_next    = '0;
                len_next    = '0;
                voiced_next = 1'b1;
            end
        end
        if (accept) begin
            p1_valid_next = 1'b1;
        end
    end

    // result register
    always_comb begin
        mask_next = mask_reg;
        if (bundle_load) begin
            mask_next = {p1_reg.last, do_cut, p1_reg.first};
        end else if (pop) begin
            mask_next = mask_reg & (mask_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (bundle_load) begin
            pos_reg[0] <= '0;
            pos_reg[1] <= p1_reg.cut_pos;
            pos_reg[2] <= p1_reg.end_pos;
        end
    end

    always_comb begin
        m_tvalid = |mask_reg;
        m_tlast  = 1'b0;
        if (mask_reg[0]) begin
            m_tdata = pos_reg[0];
        end else if (mask_reg[1]) begin
            m_tdata = pos_reg[1];
        end else begin
            m_tdata = pos_reg[2];
            m_tlast = mask_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg        <= '0;
            hop_cnt_reg  <= '0;
            p1_valid_reg <= 1'b0;
            sum_reg      <= '0;
            len_reg      <= '0;
            voiced_reg   <= 1'b1;
            mask_reg     <= '0;
        end else begin
            n_reg        <= n_next;
            hop_cnt_reg  <= hop_cnt_next;
            p1_valid_reg <= p1_valid_next;
            sum_reg      <= sum_next;
            len_reg      <= len_next;
            voiced_reg   <= voiced_next;
            mask_reg     <= mask_next;
        end
    end

endmodule
`default_nettype wire

[dv/silence_slice_point_detector_test.sv]
// Self-checking testbench: random sample streams, register setups and cut point scoreboard.
`timescale 1ns / 1ps
module silence_slice_point_detector_test;
    import sspd_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             last;
    } cut_t;

    class cut_scoreboard;
        logic [THR_W-1:0]    thr;
        logic [WIN_W-1:0]    win_len;
        logic [HOP_W-1:0]    hop_len;
        logic [GAP_W-1:0]    min_gap;
        logic signed [SAMPLE_W-1:0] ring [MAX_WINDOW_DEF];
        logic [SUM_W-1:0]    win_sum;
        longint unsigned     seen;
        longint unsigned     countdown;
        longint unsigned     since_cut;
        bit                  voiced;
        cut_t                expected_cuts[$];
        int                  mismatches;

        function new();
            thr = THR_RESET;
            win_len = WIN_RESET;
            hop_len = HOP_RESET;
            min_gap = GAP_RESET;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            win_sum = '0;
            seen = 0;
            countdown = 0;
            since_cut = 0;
            voiced = 1'b1;
        endfunction

        function longint unsigned clip32(longint unsigned v);
            return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
        endfunction

        function void add_cut(logic [POS_W-1:0] pos, logic last);
            cut_t c;
            c.pos = pos;
            c.last = last;
            expected_cuts = {expected_cuts, c};
        endfunction

        function void set_register(reg_idx_t idx, logic [PDATA_W-1:0] val);
            case (idx)
                REG_QUIET_THRESHOLD: thr = val[THR_W-1:0];
                REG_WINDOW_LENGTH:   win_len = val[WIN_W-1:0];
                REG_HOP_SIZE:        hop_len = val[HOP_W-1:0];
                REG_MIN_GAP:         min_gap = val[GAP_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] smp, bit last);
            longint unsigned w;
            longint unsigned hop;
            longint unsigned n;
            longint unsigned mag;
            longint s;
            bit now_voiced;
            w = (win_len == 0) ? 1 : ((win_len > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : win_len);
            hop = (hop_len == 0) ? 1 : hop_len;
            n = seen;
            if (n == 0) add_cut('0, 1'b0);
            if (n >= w) begin
                if (countdown == 0) begin
                    s = $signed(win_sum);
                    mag = (s < 0) ? -s : s;
                    now_voiced = !(mag < longint'(thr) * w);
                    if (now_voiced != voiced && since_cut > min_gap) begin
                        since_cut = 0;
                        add_cut(POS_W'(clip32(n - w + w / 2)), 1'b0);
                    end
                    voiced = now_voiced;
                    since_cut = clip32(since_cut + hop);
                    countdown = hop - 1;
                end else begin
                    countdown--;
                end
            end
            win_sum = win_sum + SUM_W'(smp);
            if (n >= w) win_sum = win_sum - SUM_W'(ring[(n - w) & (MAX_WINDOW_DEF - 1)]);
            ring[n & (MAX_WINDOW_DEF - 1)] = smp;
            seen = clip32(n + 1);
            if (last) begin
                add_cut(POS_W'(clip32(n + 1)), 1'b1);
                restart();
            end
        endfunction

        function void check_cut(logic [POS_W-1:0] pos, logic last);
            cut_t want;
            if (expected_cuts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected cut transaction: pos %0d last %0b", pos, last);
                return;
            end
            want = expected_cuts.pop_front();
            if (pos !== want.pos || last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("cut mismatch: expected pos %0d last %0b, got pos %0d last %0b",
                             want.pos, want.last, pos, last);
            end
        endfunction

        function void flush_pending();
            cut_t want;
            while (expected_cuts.size() != 0) begin
                want = expected_cuts.pop_front();
                mismatches++;
                if (mismatches <= 10)
                    $display("missing cut transaction: pos %0d last %0b", want.pos, want.last);
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [PDATA_W-1:0]    pwdata = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata = '0;   // [15:0] sample
    logic                  s_tlast = 1'b0; // last_sample
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [POS_W-1:0]      m_tdata;        // [31:0] cut_position
    logic                  m_tlast;        // last_cut

    bit calm = 1'b0;
    int hold_asks = 0;
    int holds_given = 0;
    int hold_left = 0;

    cut_scoreboard sb = new();

    silence_slice_point_detector dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #2 aclk = ~aclk;

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (hold_asks != holds_given) begin
            holds_given++;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 26);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_cut(m_tdata, m_tlast);
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic apb_write(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.set_register(idx, val);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic configure(input logic [PDATA_W-1:0] thr, input logic [PDATA_W-1:0] win,
                             input logic [PDATA_W-1:0] hop, input logic [PDATA_W-1:0] gap);
        apb_write(REG_QUIET_THRESHOLD, thr);
        apb_write(REG_WINDOW_LENGTH, win);
        apb_write(REG_HOP_SIZE, hop);
        apb_write(REG_MIN_GAP, gap);
    endtask

    task automatic send_item(input logic [SAMPLE_W-1:0] smp, input bit last);
        while (!calm && $urandom_range(0, 99) < 26) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= smp;
        s_tlast <= last;
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        sb.note_sample(smp, last);
        @(negedge aclk);
    endtask

    task automatic play_stream(input int len, input int level, input int seg_max,
                               input bit mark_last);
        int seg_left;
        bit loud;
        bit neg;
        logic [SAMPLE_W-1:0] smp;
        seg_left = 0;
        loud = 1'b1;
        neg = 1'b0;
        for (int k = 0; k < len; k++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(1, seg_max);
                loud = 1'($urandom_range(0, 1));
                neg = 1'($urandom_range(0, 1));
            end
            seg_left--;
            if ($urandom_range(0, 9) == 0)
                smp = 16'($urandom);
            else if (loud && neg)
                smp = 16'(32'd0 - $urandom_range(2 * level + 1, 32768));
            else if (loud)
                smp = 16'($urandom_range(2 * level + 1, 32767));
            else
                smp = 16'($urandom_range(0, 2 * (level / 3)) - level / 3);
            send_item(smp, mark_last && (k == len - 1));
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        while (sb.expected_cuts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        int lvl;
        int win;
        int budget;
        int len;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // two short streams under reset setup: only start and length
        send_item(16'sh7FFF, 1'b0);
        send_item(16'sh8000, 1'b0);
        send_item(16'sh0000, 1'b0);
        send_item(16'sh0001, 1'b1);
        send_item(16'shFFFF, 1'b1);
        settle();

        // zero window, zero hop, zero threshold: never quiet
        configure(32'd0, 32'd0, 32'd0, 32'd0);
        send_item(16'sh0000, 1'b0);
        send_item(16'sh0000, 1'b0);
        send_item(16'sh1234, 1'b0);
        send_item(16'shEDCB, 1'b1);
        settle();

        configure(32'd300, 32'd1, 32'd1, 32'd0);
        send_item(16'd1000, 1'b0);
        send_item(16'd1000, 1'b0);
        send_item(16'd0, 1'b0);
        send_item(16'd0, 1'b0);
        send_item(-16'sd1000, 1'b0);
        send_item(16'd5, 1'b0);
        settle();
        // change setup mid-stream, then finish the stream
        configure(32'd65535, 32'd2, 32'd3, 32'd1);
        send_item(16'd7, 1'b0);
        send_item(16'sh8000, 1'b0);
        send_item(16'd0, 1'b0);
        send_item(16'd3, 1'b1);
        settle();

        configure(32'd32768, 32'd4096, 32'd8191, 32'hFFFF_FFFF);
        send_item(16'sh8000, 1'b0);
        send_item(16'sh7FFF, 1'b0);
        send_item(16'sh5555, 1'b1);
        settle();

        for (int ph = 0; ph < 5; ph++) begin
            calm = (ph == 1);
            lvl = $urandom_range(20, 400);
            win = $urandom_range(1, 16);
            configure(lvl, win, $urandom_range(1, 6), $urandom_range(0, 3 * win));
            budget = 48;
            while (budget > 0) begin
                len = $urandom_range(1, 60);
                if (len > budget) len = budget;
                play_stream(len, lvl, 3 * win + 4, 1'b1);
                budget -= len;
            end
            settle();
        end
        calm = 1'b0;

        // hold the result side while short streams keep arriving
        configure(32'd100, 32'd1, 32'd1, 32'd0);
        hold_asks++;
        budget = 60;
        while (budget > 0) begin
            len = $urandom_range(1, 3);
            play_stream(len, 100, 4, 1'b1);
            budget -= len;
        end
        settle();

        // oversized window clamps to the ring depth
        configure(32'd100, 32'd8191, 32'd64, 32'd0);
        play_stream(40, 100, 2500, 1'b1);
        settle();

        sb.flush_pending();
        if (sb.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
